// File: rtl/core/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types and constants of the tiled texel encoder: texel and result
// payloads, texture format codes, register indexes and the encoding constants.
// ----------------------------------------------------------------------------
package tte_pkg;

    localparam int PIX_W      = 10;
    localparam int CH_W       = 8;
    localparam int OFF_W      = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SUM_W      = 10;
    localparam int INTRA_W    = 5;

    // Intensity is sum / 3, done as (sum * 683) >> 11, exact for sums up to 765.
    localparam logic [SUM_W-1:0] INV3_MUL   = 10'd683;
    localparam int               INV3_SHIFT = 11;

    localparam logic [CH_W-1:0]  ALPHA_OPAQUE_MIN = 8'd224;
    localparam logic [OFF_W-1:0] RGBA8_GB_OFFSET  = 22'd32;

    typedef enum logic [2:0] {
        FMT_I4     = 3'd0,
        FMT_I8     = 3'd1,
        FMT_IA4    = 3'd2,
        FMT_IA8    = 3'd3,
        FMT_RGB565 = 3'd4,
        FMT_RGB5A3 = 3'd5,
        FMT_RGBA8  = 3'd6
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_FORMAT   = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_idx;

    localparam logic [1:0] NIB_NONE = 2'd0;
    localparam logic [1:0] NIB_HIGH = 2'd1;
    localparam logic [1:0] NIB_LOW  = 2'd2;

    localparam logic [1:0] CNT_ONE = 2'd1;
    localparam logic [1:0] CNT_TWO = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [CH_W-1:0]  texel_red;
        logic [CH_W-1:0]  texel_green;
        logic [CH_W-1:0]  texel_blue;
        logic [CH_W-1:0]  texel_alpha;
    } t_pix;

    typedef struct packed {
        logic [OFF_W-1:0] byte_offset;
        logic [CH_W-1:0]  first_byte;
        logic [CH_W-1:0]  second_byte;
        logic [1:0]       byte_count;
        logic [1:0]       nibble_mode;
        logic             last_write;
    } t_res;

    // Encoded texel between the pipeline and the output stage. An RGBA8 texel
    // carries its green/blue pair for the second write.
    typedef struct packed {
        t_res            first;
        logic            split;
        logic [CH_W-1:0] gb_first;
        logic [CH_W-1:0] gb_second;
    } t_enc;

endpackage

// File: rtl/core/tte_stream_if.sv
// ----------------------------------------------------------------------------
// tte_stream_if
// Valid/ready stream channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface tte_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tte_calc.sv
// ----------------------------------------------------------------------------
// tte_calc
// Three-stage encode pipeline: range check and tile geometry, then the tile
// row multiply and intensity, then the final offset and byte packing.
// ----------------------------------------------------------------------------
module tte_calc #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_v,
    input  tte_pkg::t_pix                   i_pix,
    input  tte_pkg::t_fmt                   i_fmt,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  i_width,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  i_height,
    output logic                            o_v,
    output tte_pkg::t_enc                   o_enc
);
    import tte_pkg::*;

    localparam int DIM_CAP = (MAX_DIM < 2047) ? MAX_DIM : 2047;
    localparam int TPR_W   = $clog2((DIM_CAP + 3) / 4 + 1);
    localparam int ROW_W   = PIX_W - 2;
    localparam int PROD_W  = ROW_W + TPR_W;
    localparam int IDX_W   = PROD_W + 1;
    localparam int EXT_W   = CFG_DATA_W + 1;

    typedef struct packed {
        t_fmt               fmt;
        logic               x_odd;
        logic [SUM_W-1:0]   sum;
        logic [ROW_W-1:0]   row;
        logic [ROW_W-1:0]   col;
        logic [TPR_W-1:0]   tpr;
        logic [INTRA_W-1:0] intra;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
        logic [CH_W-1:0]    a;
    } t_s1;

    typedef struct packed {
        t_fmt               fmt;
        logic               x_odd;
        logic [PROD_W-1:0]  prod;
        logic [ROW_W-1:0]   col;
        logic [INTRA_W-1:0] intra;
        logic [CH_W-1:0]    inten;
        logic [CH_W-1:0]    r;
        logic [CH_W-1:0]    g;
        logic [CH_W-1:0]    b;
        logic [CH_W-1:0]    a;
    } t_s2;

    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_enc r_s3, n_s3;

    logic [CFG_DATA_W-1:0]  w_clamp, h_clamp;
    logic [EXT_W-1:0]       w_ext;
    logic [TPR_W-1:0]       tpr8, tpr4;
    logic                   in_range, fmt_ok;
    logic [2*SUM_W-1:0]     inten_prod;
    logic [IDX_W-1:0]       tile_idx;
    logic [OFF_W-1:0]       tile_base;

    // Stage 1: range check, channel sum and per-format tile geometry.
    always_comb begin
        w_clamp = (int'(i_width) > MAX_DIM) ? CFG_DATA_W'(MAX_DIM) : i_width;
        h_clamp = (int'(i_height) > MAX_DIM) ? CFG_DATA_W'(MAX_DIM) : i_height;
        w_ext   = EXT_W'(w_clamp);
        tpr8    = TPR_W'((w_ext + EXT_W'(7)) >> 3);
        tpr4    = TPR_W'((w_ext + EXT_W'(3)) >> 2);
        in_range = (CFG_DATA_W'(i_pix.pixel_x) < w_clamp)
                && (CFG_DATA_W'(i_pix.pixel_y) < h_clamp);
        fmt_ok   = (i_fmt <= FMT_RGBA8);

        n_s1       = '0;
        n_s1.fmt   = i_fmt;
        n_s1.x_odd = i_pix.pixel_x[0];
        n_s1.sum   = SUM_W'(i_pix.texel_red) + SUM_W'(i_pix.texel_green)
                   + SUM_W'(i_pix.texel_blue);
        n_s1.r     = i_pix.texel_red;
        n_s1.g     = i_pix.texel_green;
        n_s1.b     = i_pix.texel_blue;
        n_s1.a     = i_pix.texel_alpha;
        unique case (i_fmt)
            FMT_I4: begin
                n_s1.row   = ROW_W'(i_pix.pixel_y[PIX_W-1:3]);
                n_s1.col   = ROW_W'(i_pix.pixel_x[PIX_W-1:3]);
                n_s1.tpr   = tpr8;
                n_s1.intra = {i_pix.pixel_y[2:0], i_pix.pixel_x[2:1]};
            end
            FMT_I8, FMT_IA4: begin
                n_s1.row   = i_pix.pixel_y[PIX_W-1:2];
                n_s1.col   = ROW_W'(i_pix.pixel_x[PIX_W-1:3]);
                n_s1.tpr   = tpr8;
                n_s1.intra = {i_pix.pixel_y[1:0], i_pix.pixel_x[2:0]};
            end
            FMT_IA8, FMT_RGB565, FMT_RGB5A3, FMT_RGBA8: begin
                n_s1.row   = i_pix.pixel_y[PIX_W-1:2];
                n_s1.col   = i_pix.pixel_x[PIX_W-1:2];
                n_s1.tpr   = tpr4;
                n_s1.intra = {i_pix.pixel_y[1:0], i_pix.pixel_x[1:0], 1'b0};
            end
            default: begin
                n_s1.row   = '0;
                n_s1.col   = '0;
                n_s1.tpr   = '0;
                n_s1.intra = '0;
            end
        endcase
    end

    // Stage 2: tiles above this row, and the intensity by reciprocal multiply.
    always_comb begin
        inten_prod  = r_s1.sum * INV3_MUL;
        n_s2.fmt    = r_s1.fmt;
        n_s2.x_odd  = r_s1.x_odd;
        n_s2.prod   = PROD_W'(r_s1.row) * PROD_W'(r_s1.tpr);
        n_s2.col    = r_s1.col;
        n_s2.intra  = r_s1.intra;
        n_s2.inten  = inten_prod[INV3_SHIFT +: CH_W];
        n_s2.r      = r_s1.r;
        n_s2.g      = r_s1.g;
        n_s2.b      = r_s1.b;
        n_s2.a      = r_s1.a;
    end

    // Stage 3: byte offset and byte packing.
    always_comb begin
        tile_idx = IDX_W'(r_s2.prod) + IDX_W'(r_s2.col);
        if (r_s2.fmt == FMT_RGBA8) begin
            tile_base = OFF_W'({tile_idx, 6'b0});
        end else begin
            tile_base = OFF_W'({tile_idx, 5'b0});
        end

        n_s3                   = '0;
        n_s3.first.byte_offset = tile_base + OFF_W'(r_s2.intra);
        n_s3.first.byte_count  = CNT_TWO;
        n_s3.first.nibble_mode = NIB_NONE;
        n_s3.first.last_write  = 1'b1;
        unique case (r_s2.fmt)
            FMT_I4: begin
                n_s3.first.byte_count = CNT_ONE;
                if (r_s2.x_odd) begin
                    n_s3.first.first_byte  = {4'b0, r_s2.inten[7:4]};
                    n_s3.first.nibble_mode = NIB_LOW;
                end else begin
                    n_s3.first.first_byte  = {r_s2.inten[7:4], 4'b0};
                    n_s3.first.nibble_mode = NIB_HIGH;
                end
            end
            FMT_I8: begin
                n_s3.first.byte_count = CNT_ONE;
                n_s3.first.first_byte = r_s2.inten;
            end
            FMT_IA4: begin
                n_s3.first.byte_count = CNT_ONE;
                n_s3.first.first_byte = {r_s2.a[7:4], r_s2.inten[7:4]};
            end
            FMT_IA8: begin
                n_s3.first.first_byte  = r_s2.a;
                n_s3.first.second_byte = r_s2.inten;
            end
            FMT_RGB565: begin
                n_s3.first.first_byte  = {r_s2.r[7:3], r_s2.g[7:5]};
                n_s3.first.second_byte = {r_s2.g[4:2], r_s2.b[7:3]};
            end
            FMT_RGB5A3: begin
                // Nearly opaque texels drop alpha and keep five bits per color.
                if (r_s2.a >= ALPHA_OPAQUE_MIN) begin
                    n_s3.first.first_byte  = {1'b1, r_s2.r[7:3], r_s2.g[7:6]};
                    n_s3.first.second_byte = {r_s2.g[5:3], r_s2.b[7:3]};
                end else begin
                    n_s3.first.first_byte  = {1'b0, r_s2.a[7:5], r_s2.r[7:4]};
                    n_s3.first.second_byte = {r_s2.g[7:4], r_s2.b[7:4]};
                end
            end
            FMT_RGBA8: begin
                n_s3.first.first_byte  = r_s2.a;
                n_s3.first.second_byte = r_s2.r;
                n_s3.first.last_write  = 1'b0;
                n_s3.split             = 1'b1;
                n_s3.gb_first          = r_s2.g;
                n_s3.gb_second         = r_s2.b;
            end
            default: begin
                n_s3.first.byte_count = CNT_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_v && in_range && fmt_ok;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_v   = r_v3;
    assign o_enc = r_s3;

endmodule

// File: rtl/core/tte_emit.sv
// ----------------------------------------------------------------------------
// tte_emit
// Output register. Presents one result per transfer and issues the second
// write of an RGBA8 texel, 32 bytes after the first, from a held copy.
// ----------------------------------------------------------------------------
module tte_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_v,
    input  tte_pkg::t_enc i_enc,
    output logic          o_rdy,
    output logic          o_valid,
    output tte_pkg::t_res o_res,
    input  logic          i_ready
);
    import tte_pkg::*;

    logic            r_ov, n_ov;
    logic            r_pend, n_pend;
    t_res            r_res, n_res;
    logic [CH_W-1:0] r_g, n_g;
    logic [CH_W-1:0] r_b, n_b;
    logic            out_xfer;

    assign out_xfer = r_ov && i_ready;
    assign o_rdy    = !r_ov || (i_ready && !r_pend);

    always_comb begin
        n_ov   = r_ov;
        n_pend = r_pend;
        n_res  = r_res;
        n_g    = r_g;
        n_b    = r_b;
        priority if (out_xfer && r_pend) begin
            n_pend            = 1'b0;
            n_res.byte_offset = r_res.byte_offset + RGBA8_GB_OFFSET;
            n_res.first_byte  = r_g;
            n_res.second_byte = r_b;
            n_res.last_write  = 1'b1;
        end else if (i_v && o_rdy) begin
            n_ov   = 1'b1;
            n_pend = i_enc.split;
            n_res  = i_enc.first;
            n_g    = i_enc.gb_first;
            n_b    = i_enc.gb_second;
        end else if (out_xfer) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_ov   <= n_ov;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_g   <= n_g;
        r_b   <= n_b;
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

// File: rtl/core/tiled_texel_encoder.sv
// ----------------------------------------------------------------------------
// tiled_texel_encoder
// A texel passes through the tte_calc registers r_s1, r_s2 and r_s3, then the
// tte_emit output register. Throughput: one texel per cycle while the output
// accepts; an RGBA8 texel's second write on the single port holds the input off.
// Reset clears all valid bits and sets format I4 and a 1x1 image.
// ----------------------------------------------------------------------------
module tiled_texel_encoder #(
    parameter int MAX_DIM = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tte_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tte_stream_if.sink                      i_pix,
    tte_stream_if.source                    o_tex
);
    import tte_pkg::*;

    t_fmt                  r_fmt;
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;

    logic pipe_en;
    logic calc_v;
    t_enc calc_enc;
    logic emit_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_I4;
            r_width  <= CFG_DATA_W'(1);
            r_height <= CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_TEX_FORMAT:   r_fmt    <= t_fmt'(i_cfg_data[2:0]);
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless its last stage is blocked.
    assign pipe_en     = !calc_v || emit_rdy;
    assign i_pix.ready = pipe_en;

    tte_calc #(
        .MAX_DIM (MAX_DIM)
    ) u_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_v      (i_pix.valid),
        .i_pix    (i_pix.data),
        .i_fmt    (r_fmt),
        .i_width  (r_width),
        .i_height (r_height),
        .o_v      (calc_v),
        .o_enc    (calc_enc)
    );

    tte_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (calc_v),
        .i_enc   (calc_enc),
        .o_rdy   (emit_rdy),
        .o_valid (o_tex.valid),
        .o_res   (o_tex.data),
        .i_ready (o_tex.ready)
    );

    // The first half of an RGBA8 texel is always followed by its second half.
    a_split_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tex.valid && o_tex.ready && !o_tex.data.last_write) |=>
        (o_tex.valid && o_tex.data.last_write
         && o_tex.data.byte_offset == $past(o_tex.data.byte_offset) + RGBA8_GB_OFFSET))
        else $error("second RGBA8 write missing or misplaced");

    // Input is only held off while a result waits at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> o_tex.valid)
        else $error("input stalled with empty output");

    // Nibble writes are single bytes with nothing in the second byte.
    a_nibble_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tex.valid && o_tex.data.nibble_mode != NIB_NONE) |->
        (o_tex.data.byte_count == CNT_ONE && o_tex.data.second_byte == '0))
        else $error("malformed nibble write");

endmodule
